// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that ante implies cons in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Constants and step tables for the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  typedef logic [5:0] step_t;
  typedef logic [3:0] widx_t;

  // Memory write request from control to the block buffer.
  typedef struct packed {
    logic        en;
    widx_t       addr;
    logic [31:0] data;
  } bufwr_t;

  function automatic logic [31:0] step_const(input step_t i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input step_t i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word used by a step.
  function automatic widx_t msg_index(input step_t i);
    logic [3:0] n;
    n = i[3:0];
    case (i[5:4])
      2'd0: return n;
      2'd1: return 4'((n << 2) + n + 4'd1);
      2'd2: return 4'((n << 1) + n + 4'd5);
      default: return 4'((n << 3) - n);
    endcase
  endfunction
endpackage

// ===== hw/rtl/md5_buf.sv =====
// ----------------------------------------------------------------------------
// md5_buf
// Sixteen-word block buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module md5_buf (
  input  logic               clk,
  input  md5_pkg::bufwr_t    wr,
  input  md5_pkg::widx_t     raddr,
  output logic [31:0]        rdata
);
  import md5_pkg::*;

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/md5_round.sv =====
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step per cycle on the working words while step is set; chain add at the end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module md5_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,    // copy chain into working words
  input  logic              step,    // apply one step with word mword
  input  md5_pkg::step_t    idx,
  input  logic [31:0]       mword,
  input  logic              fold,    // add working words into chain
  input  logic              reinit,  // restore initial chain
  output logic [127:0]      chain
);
  import md5_pkg::*;

  logic [31:0] ca, cb, cc, cd;
  logic [31:0] a, b, c, d;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    case (idx[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s   = rot_amount(idx);
    sum = a + f + step_const(idx) + mword;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ca <= INIT_A; cb <= INIT_B; cc <= INIT_C; cd <= INIT_D;
    end else if (reinit) begin
      ca <= INIT_A; cb <= INIT_B; cc <= INIT_C; cd <= INIT_D;
    end else if (fold) begin
      ca <= ca + a; cb <= cb + b; cc <= cc + c; cd <= cd + d;
    end
    if (load) begin
      a <= ca; b <= cb; c <= cc; d <= cd;
    end else if (step) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  assign chain = {cd, cc, cb, ca};

  `ASSERT_ALWAYS(a_excl, clk, rst, !(load && step), "load and step together")
  `ASSERT_ALWAYS(a_fold, clk, rst, !(fold && (step || reinit)), "fold overlaps")
  `ASSERT_NEXT(a_reinit, clk, rst, reinit, chain[31:0] == INIT_A, "reinit failed")
endmodule

// ===== hw/rtl/md5_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md5_hash_engine
// MD5 (RFC 1321) message digest, at most one message byte per request.
// ----------------------------------------------------------------------------
// A byte that does not finish a block is taken as follows: the buffer word
// is read, then written back with the byte merged in. The byte that fills a
// block starts the compression, 64 steps at one step a cycle with the message
// word read from the buffer in the cycle before its step. A request with last
// set adds the padding and the length word by word (one or two passes of up
// to 16 writes), compresses one or two blocks, and presents the digest on a
// registered output; the block re-initializes and can take the next message
// while the digest waits to be taken, and holds the next digest back until
// the previous one has been taken. A new byte is taken only once the last one
// has been merged and any compression or padding it started is done.
module md5_hash_engine (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // byte_valid
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // [63:0] digest_low, [127:64] digest_high
);
  import md5_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MERGE = 4'd1;  // buffer word read, merge byte
  localparam logic [3:0] S_CLOAD = 4'd2;  // load working words, prefetch word 0
  localparam logic [3:0] S_CRUN  = 4'd3;  // 64 steps
  localparam logic [3:0] S_FOLD  = 4'd4;
  localparam logic [3:0] S_PREAD = 4'd5;  // read word holding pad position
  localparam logic [3:0] S_PMRG  = 4'd6;  // write 0x80 merged, zero rest
  localparam logic [3:0] S_PZERO = 4'd7;  // zero / length words
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]   state;
  logic [63:0]  bit_count;
  logic [7:0]   held_byte;
  logic         held_last, pad_mode, len_done;
  step_t        round_step;
  widx_t        zidx;
  logic [63:0]  len;
  logic [31:0]  rdata;
  logic [127:0] chain;
  bufwr_t       wr;
  widx_t        raddr;
  logic         ld, stp, fold, reinit;
  logic [5:0]   pos;
  logic [4:0]   sh;
  logic [31:0]  merged, padw;

  assign pos    = bit_count[8:3];
  assign sh     = {pos[1:0], 3'b000};
  assign merged = (rdata & ~(32'hff << sh)) | ({24'd0, held_byte} << sh);
  // Keep bytes below pos, 0x80 at pos, zero above.
  assign padw   = (rdata & ~(32'hffffffff << sh)) | (32'h80 << sh);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    wr     = '{en: 1'b0, addr: pos[5:2], data: merged};
    raddr  = pos[5:2];
    ld     = 1'b0;
    stp    = 1'b0;
    fold   = 1'b0;
    reinit = 1'b0;
    unique case (state)
      S_MERGE: wr.en = 1'b1;
      S_CLOAD: begin
        ld    = 1'b1;
        raddr = msg_index(6'd0);
      end
      S_CRUN: begin
        stp   = 1'b1;
        raddr = msg_index(6'(round_step + 6'd1));
      end
      S_FOLD: fold = 1'b1;
      S_PMRG: wr = '{en: 1'b1, addr: pos[5:2], data: padw};
      S_PZERO: begin
        wr.en   = 1'b1;
        wr.addr = zidx;
        wr.data = (zidx == 4'd14 && len_done) ? len[31:0] :
                  (zidx == 4'd15 && len_done) ? len[63:32] : 32'd0;
      end
      // Restore the chain only once the digest register is free.
      S_OUT: reinit = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  md5_buf u_buf (.clk(clk), .wr(wr), .raddr(raddr), .rdata(rdata));

  md5_round u_round (
    .clk(clk), .rst(rst), .load(ld), .step(stp), .idx(round_step), .mword(rdata),
    .fold(fold), .reinit(reinit), .chain(chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bit_count  <= '0;
      round_step <= '0;
      m_tvalid   <= 1'b0;
      held_last  <= 1'b0;
      pad_mode   <= 1'b0;
      len_done   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          held_byte <= s_tdata;
          held_last <= s_tlast;
          pad_mode  <= 1'b0;
          if (s_tuser) state <= S_MERGE;
          else if (s_tlast) state <= S_PREAD;
        end
        S_MERGE: begin
          bit_count <= bit_count + 64'd8;
          if (pos == 6'd63) state <= S_CLOAD;
          else if (held_last) state <= S_PREAD;
          else state <= S_IDLE;
        end
        S_CLOAD: begin
          round_step <= '0;
          state      <= S_CRUN;
        end
        S_CRUN: begin
          round_step <= 6'(round_step + 6'd1);
          if (round_step == 6'h3F) state <= S_FOLD;
        end
        S_FOLD: begin
          if (pad_mode) begin
            if (len_done) begin
              state <= S_OUT;
            end else begin
              state    <= S_PZERO;
              len_done <= 1'b1;  // second block carries the length
            end
          end else if (held_last) state <= S_PREAD;
          else state <= S_IDLE;
          zidx <= '0;
        end
        S_PREAD: begin
          len      <= bit_count;
          pad_mode <= 1'b1;
          len_done <= (pos < 6'd56);
          state    <= S_PMRG;
        end
        S_PMRG: begin
          // Pad in word 15 leaves no words to zero; else zero from the next word to 15.
          if (pos[5:2] == 4'd15) begin
            state <= S_CLOAD;
          end else begin
            zidx  <= 4'(pos[5:2] + 4'd1);
            state <= S_PZERO;
          end
        end
        S_PZERO: begin
          zidx <= 4'(zidx + 4'd1);
          if (zidx == 4'd15) state <= S_CLOAD;
        end
        S_OUT: begin
          // Hold the new digest until the previous one has been taken.
          if (!m_tvalid || m_tready) begin
            m_tdata   <= chain;
            m_tvalid  <= 1'b1;
            bit_count <= '0;
            pad_mode  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rdy, clk, rst, !(s_tready && state != S_IDLE), "ready outside idle")
  `ASSERT_NEXT(a_out, clk, rst, state == S_OUT, m_tvalid, "digest not presented")
  `ASSERT_ALWAYS(a_step, clk, rst, (state == S_CRUN) || (round_step == 6'd0), "stray step")
endmodule
